>>> hdl/rfst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfst_pkg : shared types and constants of the store trace unit
// Request and status codes, queue command and result layouts.
// ----------------------------------------------------------------------------
package rfst_pkg;

	// request kinds carried on the input tuser
	typedef enum logic [2:0] {
		REQ_STORE  = 3'd0,
		REQ_ARM    = 3'd1,
		REQ_DISARM = 3'd2,
		REQ_CLEAR  = 3'd3,
		REQ_READ   = 3'd4
	} rfst_req_type_t;

	// response status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} rfst_status_t;

	// work handed from front to back
	typedef enum logic [1:0] {
		CMD_LOG   = 2'd0,
		CMD_ACK   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_READ  = 2'd3
	} rfst_kind_t;

	localparam int          PHYS_W     = 29;
	localparam logic [28:0] DEFAULT_LO = 29'h0000_7568;
	localparam logic [28:0] DEFAULT_HI = 29'h0000_756C;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPW         = $clog2(QUEUE_DEPTH);
	localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [63:0] seq;
		logic [31:0] addr;
		logic [31:0] value;
		logic [31:0] pc;
		logic [31:0] ra;
		logic [31:0] frame;
		logic [7:0]  context_byte;
		logic [2:0]  size;
	} rfst_entry_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] store_addr;
		logic [31:0] store_value;
		logic [31:0] store_pc;
		logic [31:0] store_ra;
		logic [2:0]  store_size;
		logic [31:0] frame_number;
		logic [7:0]  context_byte;
		logic [31:0] range_lo;
		logic [31:0] range_hi;
		logic [6:0]  read_count;
	} rfst_req_t;

	typedef struct packed {
		rfst_kind_t  kind;
		logic [1:0]  status;
		logic [3:0]  slot;
		logic [6:0]  read_count;
		rfst_entry_t entry;
	} rfst_cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  slot;
		rfst_entry_t entry;
		logic        last;
	} rfst_result_t;

endpackage

>>> hdl/range_filtered_store_trace.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_filtered_store_trace : address range store trace unit
//
// Requests arrive on the s_axis channel, the kind in tuser, the fields in
// tdata. Stores whose touched bytes overlap an armed range are logged with
// a running sequence number in a ring of TRACE_DEPTH entries; arm, disarm
// and clear answer with one result, a read returns up to MAX_READ recent
// entries oldest first, tlast on the final one.
// The front matches a store against all armed ranges in the cycle it is
// taken and passes work through a four-entry queue to the back end. Stores
// and single-result requests run at one per cycle while no read is walking
// the ring; a result passes through the queue and the result register
// before it is presented on m_axis. A read walks each entry through the
// B_RADDR and B_RDATA states on the ring's registered read port. While
// m_axis is stalled the result register holds; logging goes on until a
// request needing the result register reaches the queue head, and
// s_axis_tready falls once the queue is full.
// Reset arms the default range in slot 0 and empties the log at once.
// ----------------------------------------------------------------------------
module range_filtered_store_trace import rfst_pkg::*; #(
	parameter int TRACE_DEPTH = 1024,
	parameter int MAX_RANGES  = 16,
	parameter int MAX_READ    = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// store_addr, store_value, store_pc, store_ra, store_size, frame_number,
	// context_byte, range_lo, range_hi, read_count, zero fill
	input  logic [247:0] s_axis_tdata,
	// req_type
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// resp_status, resp_slot, entry_seq, entry_addr, entry_value, entry_pc,
	// entry_ra, entry_frame, entry_context, entry_size, zero fill
	output logic [247:0] m_axis_tdata,
	output logic         m_axis_tlast
);

	rfst_req_t    req;
	rfst_cmd_t    push_cmd;
	rfst_cmd_t    head;
	rfst_result_t res;
	logic         q_push;
	logic         q_full;
	logic         q_valid;
	logic         q_pop;

	// unpack the request
	assign req.req_type     = s_axis_tuser;
	assign req.store_addr   = s_axis_tdata[31:0];
	assign req.store_value  = s_axis_tdata[63:32];
	assign req.store_pc     = s_axis_tdata[95:64];
	assign req.store_ra     = s_axis_tdata[127:96];
	assign req.store_size   = s_axis_tdata[130:128];
	assign req.frame_number = s_axis_tdata[162:131];
	assign req.context_byte = s_axis_tdata[170:163];
	assign req.range_lo     = s_axis_tdata[202:171];
	assign req.range_hi     = s_axis_tdata[234:203];
	assign req.read_count   = s_axis_tdata[241:235];

	rfst_front #(
		.MAX_RANGES (MAX_RANGES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.req      (req),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	rfst_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (head)
	);

	rfst_back #(
		.TRACE_DEPTH (TRACE_DEPTH),
		.MAX_READ    (MAX_READ)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (head),
		.q_pop     (q_pop),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	// pack the result
	assign m_axis_tdata = {7'd0, res.entry.size, res.entry.context_byte,
		res.entry.frame, res.entry.ra, res.entry.pc, res.entry.value,
		res.entry.addr, res.entry.seq, res.slot, res.status};
	assign m_axis_tlast = res.last;

	// the queue is never pushed while full
	assert property (@(posedge clk) disable iff (!arst_n) !(q_push && q_full))
		else $error("command pushed into a full queue");

	// an error answer is a single, last result
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.status != STAT_OK |-> m_axis_tlast)
		else $error("error response without last marker");

	// an error answer carries no log entry
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.status != STAT_OK |-> res.entry == '0)
		else $error("error response carries entry data");

	// a pop only happens with something in the queue
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from an empty queue");

endmodule

>>> hdl/rfst_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfst_front : request classifier and range table
// Matches stores against the armed ranges, arms and disarms ranges, and
// queues the work that the back end carries out.
// ----------------------------------------------------------------------------
module rfst_front import rfst_pkg::*; #(
	parameter int MAX_RANGES = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  rfst_req_t req,
	input  logic      q_full,
	output logic      q_push,
	output rfst_cmd_t q_cmd
);

	localparam int ACW = $clog2(MAX_RANGES + 1);

	logic [PHYS_W-1:0] watch_lo_q [MAX_RANGES];
	logic [PHYS_W-1:0] watch_hi_q [MAX_RANGES];
	logic [ACW-1:0]    armed_q;

	logic [PHYS_W-1:0] phys;
	logic [PHYS_W:0]   past;
	logic              hit;
	logic              keep;
	logic              arm_ok;
	logic              disarm;
	logic              accept;

	// overlap of the touched bytes with every armed range
	assign phys = req.store_addr[PHYS_W-1:0];
	assign past = {1'b0, phys} + (PHYS_W + 1)'(req.store_size);

	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < MAX_RANGES; i++) begin
			if (ACW'(i) < armed_q && past > {1'b0, watch_lo_q[i]} &&
					phys < watch_hi_q[i]) begin
				hit = 1'b1;
			end
		end
	end

	// classify the request
	always_comb begin
		q_cmd                    = '0;
		q_cmd.kind               = CMD_ACK;
		q_cmd.status             = STAT_OK;
		q_cmd.read_count         = req.read_count;
		q_cmd.entry.addr         = req.store_addr;
		q_cmd.entry.value        = req.store_value;
		q_cmd.entry.pc           = req.store_pc;
		q_cmd.entry.ra           = req.store_ra;
		q_cmd.entry.frame        = req.frame_number;
		q_cmd.entry.context_byte = req.context_byte;
		q_cmd.entry.size         = req.store_size;
		keep   = 1'b0;
		arm_ok = 1'b0;
		disarm = 1'b0;
		case (req.req_type)
			REQ_STORE: begin
				q_cmd.kind = CMD_LOG;
				keep       = hit;
			end
			REQ_ARM: begin
				keep = 1'b1;
				if (armed_q >= ACW'(MAX_RANGES)) begin
					q_cmd.status = STAT_FULL;
				end else if (req.range_lo >= req.range_hi) begin
					q_cmd.status = STAT_EMPTY;
				end else begin
					arm_ok     = 1'b1;
					q_cmd.slot = 4'(armed_q);
				end
			end
			REQ_DISARM: begin
				keep   = 1'b1;
				disarm = 1'b1;
			end
			REQ_CLEAR: begin
				keep       = 1'b1;
				q_cmd.kind = CMD_CLEAR;
			end
			REQ_READ: begin
				keep       = 1'b1;
				q_cmd.kind = CMD_READ;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept && keep;

	// update the range table on an accepted transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_RANGES; i++) begin
				watch_lo_q[i] <= (i == 0) ? DEFAULT_LO : '0;
				watch_hi_q[i] <= (i == 0) ? DEFAULT_HI : '0;
			end
			armed_q <= ACW'(1);
		end else if (accept) begin
			if (disarm) begin
				armed_q <= '0;
			end
			if (arm_ok) begin
				armed_q <= armed_q + ACW'(1);
				for (int i = 0; i < MAX_RANGES; i++) begin
					if (armed_q == ACW'(i)) begin
						watch_lo_q[i] <= req.range_lo[PHYS_W-1:0];
						watch_hi_q[i] <= req.range_hi[PHYS_W-1:0];
					end
				end
			end
		end
	end

endmodule

>>> hdl/rfst_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfst_queue : command queue between front and back
// A short register queue so that either side can stall on its own.
// ----------------------------------------------------------------------------
module rfst_queue import rfst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  rfst_cmd_t push_cmd,
	output logic      full,
	input  logic      pop,
	output logic      valid,
	output rfst_cmd_t head
);

	rfst_cmd_t      slots_q [QUEUE_DEPTH];
	logic [QPW-1:0] wr_q;
	logic [QPW-1:0] rd_q;
	logic [QCW-1:0] count_q;

	assign full  = (count_q == QCW'(QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign head  = slots_q[rd_q];

	// store the pushed command
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_cmd;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

endmodule

>>> hdl/rfst_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfst_back : trace ring and response sequencer
// Writes logged stores into the ring, clears it, walks recent entries
// for a read and drives the result register.
// ----------------------------------------------------------------------------
module rfst_back import rfst_pkg::*; #(
	parameter int TRACE_DEPTH = 1024,
	parameter int MAX_READ    = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	input  rfst_cmd_t    q_head,
	output logic         q_pop,
	output logic         res_valid,
	input  logic         res_ready,
	output rfst_result_t res
);

	localparam int AW   = (TRACE_DEPTH > 1) ? $clog2(TRACE_DEPTH) : 1;
	localparam int FW   = $clog2(TRACE_DEPTH + 1);
	localparam int CMPW = (FW > 7) ? FW : 7;
	localparam int SW   = ((AW > 7) ? AW : 7) + 2;

	typedef enum logic [1:0] {
		B_IDLE,
		B_RADDR,
		B_RDATA
	} bstate_t;

	rfst_entry_t mem [TRACE_DEPTH];
	rfst_entry_t rd_data_s1;

	bstate_t      state_q;
	logic [AW-1:0] wp_q;
	logic [63:0]   evt_q;
	logic [AW-1:0] rd_addr_q;
	logic [6:0]    left_q;
	logic          out_valid_q;
	rfst_result_t  out_q;

	logic          out_free;
	logic          log_we;
	rfst_entry_t   log_entry;
	logic [FW-1:0] avail;
	logic [6:0]    want;
	logic [6:0]    cnt;
	logic [SW-1:0] sum;
	logic [AW-1:0] start;
	logic          load_out;
	rfst_result_t  out_next;

	assign out_free  = !out_valid_q || res_ready;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	// pop the head once its work can be done this cycle
	always_comb begin
		q_pop = 1'b0;
		if (state_q == B_IDLE && q_valid) begin
			case (q_head.kind)
				CMD_LOG:   q_pop = 1'b1;
				CMD_ACK:   q_pop = out_free;
				CMD_CLEAR: q_pop = out_free;
				CMD_READ:  q_pop = 1'b1;
				default:   q_pop = 1'b1;
			endcase
		end
	end

	assign log_we = q_pop && q_head.kind == CMD_LOG;

	always_comb begin
		log_entry     = q_head.entry;
		log_entry.seq = evt_q;
	end

	// entries available: the event count, capped at the ring depth
	assign avail = (evt_q < 64'(TRACE_DEPTH)) ? FW'(evt_q) : FW'(TRACE_DEPTH);

	// size the read and find its oldest entry
	always_comb begin
		want = (q_head.read_count > 7'(MAX_READ)) ? 7'(MAX_READ) : q_head.read_count;
		cnt  = (CMPW'(avail) < CMPW'(want)) ? 7'(avail) : want;
		sum  = SW'(wp_q) + SW'(TRACE_DEPTH) - SW'(cnt);
		start = (sum >= SW'(TRACE_DEPTH)) ? AW'(sum - SW'(TRACE_DEPTH)) : AW'(sum);
	end

	// load the result register from an answer or from the ring
	always_comb begin
		load_out = 1'b0;
		out_next = '0;
		if (state_q == B_RDATA) begin
			load_out       = out_free;
			out_next.entry = rd_data_s1;
			out_next.last  = (left_q == 7'd1);
		end else begin
			load_out        = q_pop && (q_head.kind == CMD_ACK || q_head.kind == CMD_CLEAR);
			out_next.status = q_head.status;
			out_next.slot   = q_head.slot;
			out_next.last   = 1'b1;
		end
	end

	// trace ring: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (log_we) begin
			mem[wp_q] <= log_entry;
		end
		if (state_q == B_RADDR) begin
			rd_data_s1 <= mem[rd_addr_q];
		end
	end

	// sequencer, ring pointers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			wp_q        <= '0;
			evt_q       <= '0;
			rd_addr_q   <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			out_valid_q <= load_out || (out_valid_q && !res_ready);
			if (load_out) begin
				out_q <= out_next;
			end
			case (state_q)
				B_IDLE: begin
					if (q_pop) begin
						case (q_head.kind)
							CMD_LOG: begin
								wp_q  <= (wp_q == AW'(TRACE_DEPTH - 1)) ? '0 : wp_q + AW'(1);
								evt_q <= evt_q + 64'd1;
							end
							CMD_CLEAR: begin
								wp_q  <= '0;
								evt_q <= '0;
							end
							CMD_READ: begin
								if (cnt != '0) begin
									rd_addr_q <= start;
									left_q    <= cnt;
									state_q   <= B_RADDR;
								end
							end
							default: begin
								// an answer needs only the result register
								state_q <= B_IDLE;
							end
						endcase
					end
				end
				B_RADDR: begin
					rd_addr_q <= (rd_addr_q == AW'(TRACE_DEPTH - 1)) ? '0 : rd_addr_q + AW'(1);
					state_q   <= B_RDATA;
				end
				B_RDATA: begin
					if (out_free) begin
						left_q  <= left_q - 7'd1;
						state_q <= (left_q == 7'd1) ? B_IDLE : B_RADDR;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule
